>>> hdl/skt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skt_pkg
// Shared types and constants for the sorted key table.
// ----------------------------------------------------------------------------
package skt_pkg;

  localparam int DEPTH      = 16;
  localparam int NAME_BYTES = 8;

  localparam int IW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int NW    = NAME_BYTES * 8;
  localparam int CMP_W = (CW > 5) ? CW : 5;

  localparam logic [1:0] ACT_INSERT = 2'd0;
  localparam logic [1:0] ACT_DELETE = 2'd1;
  localparam logic [1:0] ACT_READ   = 2'd2;

  localparam logic [1:0] STS_OK    = 2'd0;
  localparam logic [1:0] STS_FULL  = 2'd1;
  localparam logic [1:0] STS_RANGE = 2'd2;

  typedef struct packed {
    logic load;
    logic fetch;
    logic ins;
    logic put;
    logic del;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic idx_ok;
    logic ins_stop;
    logic ins_head;
    logic del_last;
  } sts_t;

endpackage

>>> hdl/sorted_key_table_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_key_table_top
// Bounded table of year/name entries kept in ascending key order.
// ----------------------------------------------------------------------------
// full insert, bad read, empty delete, unused action: result the cycle after accept
// insert: fetch, shift per entry moved, head write if least; empty: head write only
// delete: fetch, a step per entry; read: fetch; one read/write port walk
// next item accepted in the cycle the result strobe is high
// synchronous reset clears the entry count and the controller; no stall on results
module sorted_key_table_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_action,
  input  logic [15:0] in_year,
  input  logic [63:0] in_name_tag,
  input  logic [3:0]  in_index,
  output logic        out_valid,
  output logic [1:0]  out_status,
  output logic [4:0]  out_removed_count,
  output logic [4:0]  out_entry_count,
  output logic [15:0] out_read_year,
  output logic [63:0] out_read_name
);

  skt_pkg::cmd_t cmd;
  skt_pkg::sts_t sts;

  skt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_action (in_action),
    .sts       (sts),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  skt_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_action         (in_action),
    .in_year           (in_year),
    .in_name_tag       (in_name_tag),
    .in_index          (in_index),
    .out_status        (out_status),
    .out_removed_count (out_removed_count),
    .out_entry_count   (out_entry_count),
    .out_read_year     (out_read_year),
    .out_read_name     (out_read_name)
  );

  ap_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == skt_pkg::STS_FULL) |->
      out_entry_count == 5'(skt_pkg::DEPTH))
    else $error("full status with room left");

  ap_range_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != skt_pkg::STS_OK) |->
      (out_read_year == '0 && out_read_name == '0 && out_removed_count == '0))
    else $error("error result carries data");

  ap_strobe_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !start) |=> !out_valid)
    else $error("result strobe held without a new item");

endmodule

>>> hdl/skt_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skt_dp
// Entry storage, walk pointers, count and result registers.
// ----------------------------------------------------------------------------
module skt_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  skt_pkg::cmd_t       cmd,
  output skt_pkg::sts_t       sts,
  input  logic [1:0]          in_action,
  input  logic [15:0]         in_year,
  input  logic [63:0]         in_name_tag,
  input  logic [3:0]          in_index,
  output logic [1:0]          out_status,
  output logic [4:0]          out_removed_count,
  output logic [4:0]          out_entry_count,
  output logic [15:0]         out_read_year,
  output logic [63:0]         out_read_name
);

  logic [15:0]            mem_key  [skt_pkg::DEPTH];
  logic [skt_pkg::NW-1:0] mem_name [skt_pkg::DEPTH];

  logic [15:0]            year_r;
  logic [skt_pkg::NW-1:0] name_r;
  logic [15:0]            rkey_r;
  logic [skt_pkg::NW-1:0] rname_r;
  logic [skt_pkg::CW-1:0] ptr_r;
  logic [skt_pkg::CW-1:0] wr_r;
  logic [skt_pkg::CW-1:0] count_r;
  logic [skt_pkg::CW-1:0] removed_r;
  logic [1:0]             status_r;
  logic                   rd_ok_r;

  logic [skt_pkg::CW-1:0] ptr_inc;
  logic [skt_pkg::CW-1:0] ptr_dec;
  logic [skt_pkg::CW-1:0] count_dec;
  logic                   match;
  logic                   rd_en;
  logic [skt_pkg::IW-1:0] rd_addr;
  logic                   wr_en;
  logic [skt_pkg::IW-1:0] wr_addr;
  logic [15:0]            wr_key;
  logic [skt_pkg::NW-1:0] wr_name;

  assign ptr_inc   = ptr_r + skt_pkg::CW'(1);
  assign ptr_dec   = ptr_r - skt_pkg::CW'(1);
  assign count_dec = count_r - skt_pkg::CW'(1);
  assign match     = (rkey_r == year_r);

  assign sts.full     = (count_r == skt_pkg::CW'(skt_pkg::DEPTH));
  assign sts.empty    = (count_r == '0);
  assign sts.idx_ok   = (skt_pkg::CMP_W'(in_index) < skt_pkg::CMP_W'(count_r));
  assign sts.ins_stop = (rkey_r <= year_r);
  assign sts.ins_head = (rkey_r > year_r) && (ptr_r == '0);
  assign sts.del_last = (ptr_r == count_dec);

  // memory port control
  always_comb begin
    rd_en   = cmd.fetch | cmd.ins | cmd.del;
    rd_addr = ptr_r[skt_pkg::IW-1:0];
    wr_en   = 1'b0;
    wr_addr = ptr_inc[skt_pkg::IW-1:0];
    wr_key  = rkey_r;
    wr_name = rname_r;
    if (cmd.ins) begin
      rd_addr = ptr_dec[skt_pkg::IW-1:0];
      wr_en   = 1'b1;
      if (rkey_r <= year_r) begin
        wr_key  = year_r;
        wr_name = name_r;
      end
    end else if (cmd.put) begin
      wr_en   = 1'b1;
      wr_addr = '0;
      wr_key  = year_r;
      wr_name = name_r;
    end else if (cmd.del) begin
      rd_addr = ptr_inc[skt_pkg::IW-1:0];
      wr_en   = !match;
      wr_addr = wr_r[skt_pkg::IW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_key[wr_addr]  <= wr_key;
      mem_name[wr_addr] <= wr_name;
    end
    if (rd_en) begin
      rkey_r  <= mem_key[rd_addr];
      rname_r <= mem_name[rd_addr];
    end
  end

  // item registers and walk pointers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      year_r    <= in_year;
      name_r    <= in_name_tag[skt_pkg::NW-1:0];
      wr_r      <= '0;
      removed_r <= '0;
      rd_ok_r   <= (in_action == skt_pkg::ACT_READ) && sts.idx_ok;
      unique case (in_action)
        skt_pkg::ACT_INSERT: begin
          ptr_r    <= count_dec;
          status_r <= sts.full ? skt_pkg::STS_FULL : skt_pkg::STS_OK;
        end
        skt_pkg::ACT_READ: begin
          ptr_r    <= skt_pkg::CW'(in_index);
          status_r <= sts.idx_ok ? skt_pkg::STS_OK : skt_pkg::STS_RANGE;
        end
        default: begin
          ptr_r    <= '0;
          status_r <= skt_pkg::STS_OK;
        end
      endcase
    end else if (cmd.ins) begin
      ptr_r <= ptr_dec;
    end else if (cmd.del) begin
      ptr_r <= ptr_inc;
      if (match) begin
        removed_r <= removed_r + skt_pkg::CW'(1);
      end else begin
        wr_r <= wr_r + skt_pkg::CW'(1);
      end
    end
  end

  // entry count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if ((cmd.ins && sts.ins_stop) || cmd.put) begin
      count_r <= count_r + skt_pkg::CW'(1);
    end else if (cmd.del && sts.del_last) begin
      count_r <= match ? wr_r : wr_r + skt_pkg::CW'(1);
    end
  end

  assign out_status        = status_r;
  assign out_removed_count = 5'(removed_r);
  assign out_entry_count   = 5'(count_r);
  assign out_read_year     = rd_ok_r ? rkey_r : '0;
  assign out_read_name     = rd_ok_r ? 64'(rname_r) : '0;

  ap_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= skt_pkg::CW'(skt_pkg::DEPTH))
    else $error("entry count beyond depth");

  ap_put_grows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.put |=> count_r == $past(count_r) + skt_pkg::CW'(1))
    else $error("head insert did not grow the count");

  ap_del_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.del && sts.del_last) |=> count_r <= $past(count_r))
    else $error("delete grew the count");

endmodule

>>> hdl/skt_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skt_ctrl
// Sequencer for insert, delete and read walks over the entry storage.
// ----------------------------------------------------------------------------
module skt_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [1:0]    in_action,
  input  skt_pkg::sts_t sts,
  output skt_pkg::cmd_t cmd,
  output logic          busy,
  output logic          out_valid
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_FETCH = 6'b000010,
    S_INS   = 6'b000100,
    S_PUT   = 6'b001000,
    S_DEL   = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t     state_r, state_nxt;
  logic [1:0] act_r;
  logic       accept;

  assign busy   = !(state_r == S_IDLE || state_r == S_DONE);
  assign accept = start && !busy;

  always_comb begin
    cmd       = '0;
    cmd.load  = accept;
    cmd.fetch = (state_r == S_FETCH);
    cmd.ins   = (state_r == S_INS);
    cmd.put   = (state_r == S_PUT);
    cmd.del   = (state_r == S_DEL);
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE, S_DONE: begin
        state_nxt = S_IDLE;
        if (accept) begin
          unique case (in_action)
            skt_pkg::ACT_INSERT: begin
              if (sts.full) begin
                state_nxt = S_DONE;
              end else if (sts.empty) begin
                state_nxt = S_PUT;
              end else begin
                state_nxt = S_FETCH;
              end
            end
            skt_pkg::ACT_DELETE: state_nxt = sts.empty ? S_DONE : S_FETCH;
            skt_pkg::ACT_READ:   state_nxt = sts.idx_ok ? S_FETCH : S_DONE;
            default:             state_nxt = S_DONE;
          endcase
        end
      end
      S_FETCH: begin
        unique case (act_r)
          skt_pkg::ACT_INSERT: state_nxt = S_INS;
          skt_pkg::ACT_DELETE: state_nxt = S_DEL;
          default:             state_nxt = S_DONE;
        endcase
      end
      S_INS: begin
        priority if (sts.ins_stop) begin
          state_nxt = S_DONE;
        end else if (sts.ins_head) begin
          state_nxt = S_PUT;
        end else begin
          state_nxt = S_INS;
        end
      end
      S_PUT: state_nxt = S_DONE;
      S_DEL: state_nxt = sts.del_last ? S_DONE : S_DEL;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      act_r <= in_action;
    end
  end

  assign out_valid = (state_r == S_DONE);

  ap_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r))
    else $error("state register not one-hot");

  ap_put_done: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_PUT |=> state_r == S_DONE)
    else $error("head write not followed by result");

  ap_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_INS || state_r == S_DEL) |-> !cmd.load)
    else $error("item taken during a walk");

endmodule

>>> sim/sorted_key_table_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_key_table_top_test
// Self-checking bench for the sorted key table. A directed sequence covers
// empty tables, head inserts, equal keys, adjacent deletes, out of range reads and
// the unused action. Random phases of fill, drain and mixed traffic follow.
// A scoreboard keeps its own copy of the table and checks every result
// strobe field by field.
// ----------------------------------------------------------------------------
module sorted_key_table_top_test;

  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam int QUIET_LIMIT = 4000;
  localparam int ITEM_TARGET = 850;

  localparam int MODE_FILL  = 0;
  localparam int MODE_DRAIN = 1;
  localparam int MODE_MIX   = 2;

  typedef struct packed {
    logic [1:0]  status;
    logic [4:0]  removed;
    logic [4:0]  count;
    logic [15:0] ryear;
    logic [63:0] rname;
  } table_result_t;

  class key_table_tracker;
    logic [15:0] keys [skt_pkg::DEPTH];
    logic [63:0] names [skt_pkg::DEPTH];
    int held;
    int errors;
    table_result_t expected_results[$];

    function new();
      held = 0;
      errors = 0;
    endfunction

    function void note_item(logic [1:0] action, logic [15:0] year, logic [63:0] tag,
                            logic [3:0] index);
      table_result_t res;
      logic [63:0] mask;
      int pos;
      int wr;
      int i;
      res = '0;
      mask = (skt_pkg::NW >= 64) ? {64{1'b1}} : ((64'd1 << skt_pkg::NW) - 64'd1);
      case (action)
        skt_pkg::ACT_INSERT: begin
          if (held >= skt_pkg::DEPTH) begin
            res.status = skt_pkg::STS_FULL;
          end else begin
            pos = 0;
            while (pos < held && keys[pos] <= year) pos++;
            for (i = held; i > pos; i--) begin
              keys[i] = keys[i - 1];
              names[i] = names[i - 1];
            end
            keys[pos] = year;
            names[pos] = tag & mask;
            held++;
          end
        end
        skt_pkg::ACT_DELETE: begin
          wr = 0;
          for (i = 0; i < held; i++) begin
            if (keys[i] == year) begin
              res.removed = res.removed + 5'd1;
            end else begin
              keys[wr] = keys[i];
              names[wr] = names[i];
              wr++;
            end
          end
          held = wr;
        end
        skt_pkg::ACT_READ: begin
          if (int'(index) < held) begin
            res.ryear = keys[index];
            res.rname = names[index];
          end else begin
            res.status = skt_pkg::STS_RANGE;
          end
        end
        default: ;
      endcase
      res.count = held[4:0];
      expected_results.push_back(res);
    endfunction

    function void check_result(table_result_t got);
      table_result_t exp;
      if (expected_results.size() == 0) begin
        $error("result strobe with no item outstanding");
        errors++;
        return;
      end
      exp = expected_results.pop_front();
      if (got.status !== exp.status) begin
        $error("status expected %0d got %0d", exp.status, got.status);
        errors++;
      end
      if (got.removed !== exp.removed) begin
        $error("removed_count expected %0d got %0d", exp.removed, got.removed);
        errors++;
      end
      if (got.count !== exp.count) begin
        $error("entry_count expected %0d got %0d", exp.count, got.count);
        errors++;
      end
      if (got.ryear !== exp.ryear) begin
        $error("read_year expected %h got %h", exp.ryear, got.ryear);
        errors++;
      end
      if (got.rname !== exp.rname) begin
        $error("read_name expected %h got %h", exp.rname, got.rname);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  in_action = skt_pkg::ACT_INSERT;
  logic [15:0] in_year = '0;
  logic [63:0] in_name_tag = '0;
  logic [3:0]  in_index = '0;
  logic        out_valid;
  logic [1:0]  out_status;
  logic [4:0]  out_removed_count;
  logic [4:0]  out_entry_count;
  logic [15:0] out_read_year;
  logic [63:0] out_read_name;

  key_table_tracker tracker = new();
  table_result_t seen_result;
  bit sender_idles = 1'b1;
  int item_count = 0;
  int quiet_cycles = 0;
  logic [15:0] key_pool [8];
  int pool_size = 8;

  sorted_key_table_top dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_action         (in_action),
    .in_year           (in_year),
    .in_name_tag       (in_name_tag),
    .in_index          (in_index),
    .out_valid         (out_valid),
    .out_status        (out_status),
    .out_removed_count (out_removed_count),
    .out_entry_count   (out_entry_count),
    .out_read_year     (out_read_year),
    .out_read_name     (out_read_name)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) begin
        seen_result.status = out_status;
        seen_result.removed = out_removed_count;
        seen_result.count = out_entry_count;
        seen_result.ryear = out_read_year;
        seen_result.rname = out_read_name;
        tracker.check_result(seen_result);
      end
      if (start && !busy) tracker.note_item(in_action, in_year, in_name_tag, in_index);
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || out_valid) quiet_cycles = 0;
    else quiet_cycles = quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic send_item(input logic [1:0] action, input logic [15:0] year,
                           input logic [63:0] tag, input logic [3:0] index);
    int gap;
    gap = 0;
    if (sender_idles) while ($urandom_range(99) < 37) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_action <= action;
    in_year <= year;
    in_name_tag <= tag;
    in_index <= index;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (action != ACT_UNUSED) item_count++;
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk);
    while (tracker.expected_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_key();
    if ($urandom_range(99) < 85) return key_pool[$urandom_range(pool_size - 1)];
    return 16'($urandom());
  endfunction

  task automatic run_phase(input int mode, input int n_items);
    int roll;
    int ins_w;
    int del_w;
    int rd_w;
    logic [1:0] action;
    pool_size = $urandom_range(1, 8);
    for (int k = 0; k < 8; k++) key_pool[k] = 16'($urandom());
    if ($urandom_range(1)) key_pool[0] = 16'h0000;
    if ($urandom_range(1)) key_pool[pool_size - 1] = 16'hffff;
    case (mode)
      MODE_FILL:  begin ins_w = 75; del_w = 5;  rd_w = 18; end
      MODE_DRAIN: begin ins_w = 20; del_w = 45; rd_w = 33; end
      default:    begin ins_w = 45; del_w = 20; rd_w = 33; end
    endcase
    for (int n = 0; n < n_items; n++) begin
      roll = $urandom_range(99);
      if (roll < ins_w) action = skt_pkg::ACT_INSERT;
      else if (roll < ins_w + del_w) action = skt_pkg::ACT_DELETE;
      else if (roll < ins_w + del_w + rd_w) action = skt_pkg::ACT_READ;
      else action = ACT_UNUSED;
      send_item(action, pick_key(), {$urandom(), $urandom()}, 4'($urandom_range(15)));
    end
  endtask

  initial begin
    int phase_no;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty table corner cases
    send_item(skt_pkg::ACT_READ, 16'h0000, 64'h0, 4'h0);
    send_item(skt_pkg::ACT_READ, 16'h0000, 64'h0, 4'hf);
    send_item(skt_pkg::ACT_DELETE, 16'h0000, 64'h0, 4'h0);
    send_item(ACT_UNUSED, 16'hffff, {64{1'b1}}, 4'hf);
    // extremes, equal keys and head insert
    send_item(skt_pkg::ACT_INSERT, 16'hffff, {64{1'b1}}, 4'h0);
    send_item(skt_pkg::ACT_INSERT, 16'h0000, 64'h0, 4'h0);
    send_item(skt_pkg::ACT_INSERT, 16'h0064, 64'h0000_0000_0000_00a1, 4'h0);
    send_item(skt_pkg::ACT_INSERT, 16'h0064, 64'h0000_0000_0000_00b2, 4'h0);
    send_item(skt_pkg::ACT_INSERT, 16'h0064, 64'h0000_0000_0000_00c3, 4'h0);
    send_item(skt_pkg::ACT_INSERT, 16'h8000, 64'h5555_5555_5555_5555, 4'h0);
    send_item(skt_pkg::ACT_INSERT, 16'h7fff, 64'haaaa_aaaa_aaaa_aaaa, 4'h0);
    send_item(skt_pkg::ACT_READ, 16'h0000, 64'h0, 4'h0);
    send_item(skt_pkg::ACT_READ, 16'h0000, 64'h0, 4'h2);
    send_item(skt_pkg::ACT_READ, 16'h0000, 64'h0, 4'h6);
    send_item(skt_pkg::ACT_READ, 16'h0000, 64'h0, 4'h7);
    // adjacent matches, then no match
    send_item(skt_pkg::ACT_DELETE, 16'h0064, 64'h0, 4'h0);
    send_item(skt_pkg::ACT_DELETE, 16'h1234, 64'h0, 4'h0);
    send_item(skt_pkg::ACT_READ, 16'h0000, 64'h0, 4'h2);
    send_item(skt_pkg::ACT_INSERT, 16'h0000, 64'h0000_0000_0000_0001, 4'h0);
    send_item(skt_pkg::ACT_READ, 16'h0000, 64'h0, 4'h1);
    send_item(skt_pkg::ACT_DELETE, 16'hffff, 64'h0, 4'h0);
    send_item(skt_pkg::ACT_DELETE, 16'h0000, 64'h0, 4'h0);
    wait_drained();

    phase_no = 0;
    while (item_count < ITEM_TARGET) begin
      sender_idles = (phase_no != 4);
      run_phase(phase_no % 3, $urandom_range(30, 70));
      if (phase_no % 2 == 1) wait_drained();
      phase_no++;
    end

    wait_drained();
    repeat (2 * skt_pkg::DEPTH + 8) @(posedge clk);
    if (tracker.errors == 0 && tracker.expected_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
